FILE: rtl/pfpa_pkg.sv
// Package for the population Fst/pi accumulator.
// Holds widths, opcode and symbol codes, the controller state type and the divider structs.
// Depends on nothing.
`default_nettype none
package pfpa_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int CFG_W    = 11;
  localparam int IDX_W    = 10;
  localparam int TAG_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ACC_W    = 56;
  localparam int FRAC_W   = 24;
  localparam int FST_W    = 32;

  // divider: divisor up to twice an accumulator, dividend carries the fraction bits
  localparam int DVS_W    = ACC_W + 1;
  localparam int DVD_W    = DVS_W + FRAC_W;
  localparam int QUO_W    = FST_W + 2;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_SYMBOL = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [TAG_W-1:0] TAG_ONE = 2'd1;
  localparam logic [TAG_W-1:0] TAG_TWO = 2'd2;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_TWO  = 8'h32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SYM,
    ST_TERM,
    ST_WAIT,
    ST_REPORT
  } state_e;

  typedef enum logic [1:0] {
    TERM_W1,
    TERM_W2,
    TERM_B,
    TERM_FST
  } term_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             big;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/pfpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module pfpa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/pfpa_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pfpa_pkg. Quotient keeps QUO_W low bits plus a sticky overflow flag.
`default_nettype none
module pfpa_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pfpa_pkg::div_req_t req_i,
  output pfpa_pkg::div_rsp_t      rsp_o
);
  import pfpa_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVD_W-1:0] dvd_q;
  logic [QUO_W-1:0] quo_q;
  logic             big_q;

  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      quo_q <= '0;
      big_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
      // remember any quotient bit pushed out of the top
      big_q <= big_q | quo_q[QUO_W-1];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.big  = big_q;
  assign rsp_o.quo  = quo_q;

endmodule
`default_nettype wire

FILE: rtl/population_fst_pi_accumulator.sv
// Two-population pi / Fst accumulator.
// Use: write num_columns on the config channel (valid/ready, always ready) while idle.
// Input channel (valid/stall) carries one item: opcode 0 sets a column's population tag,
// opcode 1 feeds the genotype byte of the next column, opcode 2 requests a report.
// Output channel (valid/stall) returns one report item per opcode 2.
// Processing: a membership write goes into the RAM as it is accepted; a genotype symbol
// is handled after the registered read of the membership RAM. A symbol that closes a
// site with both counts nonzero adds 3 divisions, within-one, within-two and between.
// A report skips the Fst division when the between sum is zero; all divisions share
// one bit-serial divider.
// Reset: the membership RAM is cleared by a pass over all MAX_COLUMNS entries (1024 by
// default), during which in_stall_o is high; config writes are taken throughout.
// Output stall: the report sits in the output register; the block keeps taking
// membership and symbol items, and a further report waits until the register frees.
// Depends on pfpa_pkg, pfpa_ram and pfpa_div.
`default_nettype none
module population_fst_pi_accumulator #(
  parameter int MAX_COLUMNS = pfpa_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pfpa_pkg::CFG_W-1:0]    cfg_num_columns_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    in_opcode_i,
  input  wire logic [pfpa_pkg::IDX_W-1:0]    in_column_index_i,
  input  wire logic [pfpa_pkg::TAG_W-1:0]    in_pop_tag_i,
  input  wire logic [pfpa_pkg::CHAR_W-1:0]   in_genotype_char_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pfpa_pkg::ACC_W-1:0]         out_pi_within_one_o,
  output logic [pfpa_pkg::ACC_W-1:0]         out_pi_within_two_o,
  output logic [pfpa_pkg::ACC_W-1:0]         out_pi_between_o,
  output logic signed [pfpa_pkg::FST_W-1:0]  out_fst_value_o,
  output logic                               out_fst_valid_o
);
  import pfpa_pkg::*;

  localparam int AW  = $clog2(MAX_COLUMNS);
  localparam int CNW = $clog2(MAX_COLUMNS + 1);
  localparam int SW  = $clog2(2 * MAX_COLUMNS + 1);
  localparam int XW  = SW + 1;
  localparam int EW  = ((CNW > CFG_W) ? CNW : CFG_W) + 1;
  localparam int PW  = 2 * XW + 2;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  state_e state_q, state_d;
  term_e  term_q;

  logic [CFG_W-1:0] ncol_q;
  logic [AW-1:0]    clr_q, col_q;
  logic [CNW-1:0]   n1_q, n2_q;
  logic [SW-1:0]    s1_q, s2_q;
  logic [ACC_W-1:0] acc_w1_q, acc_w2_q, acc_b_q;
  logic [CHAR_W-1:0] gch_q;
  logic             neg_q;
  logic [FST_W-1:0] fst_q;
  logic             fvalid_q;
  logic             out_valid_q;

  logic             accept, out_free, ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [TAG_W-1:0] ram_wdata, ram_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  pfpa_ram #(.WIDTH(TAG_W), .DEPTH(MAX_COLUMNS)) u_member (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  pfpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // symbol update
  logic             sym_ok;
  logic [1:0]       dose;
  logic [CNW-1:0]   n1_new, n2_new;
  logic [SW-1:0]    s1_new, s2_new;
  logic [EW-1:0]    eff, col_next;
  logic             site_end;

  assign sym_ok = (gch_q >= CH_ZERO) && (gch_q <= CH_TWO);
  assign dose   = 2'(gch_q - CH_ZERO);

  always_comb begin
    n1_new = n1_q;
    n2_new = n2_q;
    s1_new = s1_q;
    s2_new = s2_q;
    if (sym_ok && ram_rdata == TAG_ONE) begin
      n1_new = n1_q + 1'b1;
      s1_new = s1_q + SW'(dose);
    end else if (sym_ok && ram_rdata == TAG_TWO) begin
      n2_new = n2_q + 1'b1;
      s2_new = s2_q + SW'(dose);
    end
  end

  always_comb begin
    if (ncol_q == '0) begin
      eff = EW'(1);
    end else if (EW'(ncol_q) > EW'(MAX_COLUMNS)) begin
      eff = EW'(MAX_COLUMNS);
    end else begin
      eff = EW'(ncol_q);
    end
  end

  assign col_next = EW'(col_q) + 1'b1;
  assign site_end = col_next >= eff;

  // division operands, widened to the product width before multiplying
  logic [PW-1:0]    xn1, xn2, xs1, xs2;
  logic [PW-1:0]    num_w1, num_w2, den_w1, den_w2, num_b, den_b;
  logic [DVS_W-1:0] fst_d, fst_s, fst_num;
  logic             fst_neg;

  assign xn1 = PW'(n1_q);
  assign xn2 = PW'(n2_q);
  assign xs1 = PW'(s1_q);
  assign xs2 = PW'(s2_q);

  always_comb begin
    num_w1 = xs1 * ((xn1 << 1) - xs1);
    num_w2 = xs2 * ((xn2 << 1) - xs2);
    den_w1 = xn1 * ((xn1 << 1) - PW'(1));
    den_w2 = xn2 * ((xn2 << 1) - PW'(1));
    num_b  = (xs1 * ((xn2 << 1) - xs2)) + (xs2 * ((xn1 << 1) - xs1));
    den_b  = (xn1 * xn2) << 2;
  end

  assign fst_d   = {acc_b_q, 1'b0};
  assign fst_s   = DVS_W'(acc_w1_q) + DVS_W'(acc_w2_q);
  assign fst_neg = fst_s > fst_d;
  assign fst_num = fst_neg ? (fst_s - fst_d) : (fst_d - fst_s);

  always_comb begin
    div_req.start = (state_q == ST_TERM);
    unique case (term_q)
      TERM_W1: begin
        div_req.dividend = {DVS_W'(num_w1), {FRAC_W{1'b0}}};
        div_req.divisor  = DVS_W'(den_w1);
      end
      TERM_W2: begin
        div_req.dividend = {DVS_W'(num_w2), {FRAC_W{1'b0}}};
        div_req.divisor  = DVS_W'(den_w2);
      end
      TERM_B: begin
        div_req.dividend = {DVS_W'(num_b), {FRAC_W{1'b0}}};
        div_req.divisor  = DVS_W'(den_b);
      end
      default: begin
        div_req.dividend = {fst_num, {FRAC_W{1'b0}}};
        div_req.divisor  = fst_d;
      end
    endcase
  end

  // saturating accumulate of a finished term
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_sel, acc_sat;

  always_comb begin
    unique case (term_q)
      TERM_W1: acc_sel = acc_w1_q;
      TERM_W2: acc_sel = acc_w2_q;
      default: acc_sel = acc_b_q;
    endcase
  end

  assign acc_sum = {1'b0, acc_sel} + (ACC_W + 1)'(div_rsp.quo);
  assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

  // Fst rounding toward zero and saturation
  logic [FST_W-1:0] mag, mag_lim, fst_res;

  always_comb begin
    if (div_rsp.big || div_rsp.quo[QUO_W-1:FST_W] != '0) begin
      mag = {1'b1, {(FST_W-1){1'b0}}};
    end else begin
      mag = div_rsp.quo[FST_W-1:0];
    end
    if (neg_q) begin
      mag_lim = (mag > {1'b1, {(FST_W-1){1'b0}}}) ? {1'b1, {(FST_W-1){1'b0}}} : mag;
      fst_res = FST_W'(0) - mag_lim;
    end else begin
      mag_lim = mag;
      fst_res = mag[FST_W-1] ? {1'b0, {(FST_W-1){1'b1}}} : mag;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(MAX_COLUMNS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_opcode_i == OP_SYMBOL) begin
          state_d = ST_SYM;
        end else if (accept && in_opcode_i == OP_REPORT) begin
          state_d = (acc_b_q == '0) ? ST_REPORT : ST_TERM;
        end
      end
      ST_SYM: begin
        if (site_end && n1_new != '0 && n2_new != '0) state_d = ST_TERM;
        else state_d = ST_IDLE;
      end
      ST_TERM: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          priority case (term_q)
            TERM_FST: state_d = ST_REPORT;
            TERM_B:   state_d = ST_IDLE;
            default:  state_d = ST_TERM;
          endcase
        end
      end
      ST_REPORT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = clr_q;
    ram_wdata  = '0;
    if (state_q == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept && in_opcode_i == OP_SET &&
                 (AW + IDX_W + 1)'(in_column_index_i) < (AW + IDX_W + 1)'(MAX_COLUMNS)) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(in_column_index_i);
      ram_wdata = in_pop_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      term_q      <= TERM_W1;
      ncol_q      <= CFG_W'(1);
      clr_q       <= '0;
      col_q       <= '0;
      n1_q        <= '0;
      n2_q        <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      acc_w1_q    <= '0;
      acc_w2_q    <= '0;
      acc_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) ncol_q <= cfg_num_columns_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_REPORT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept && in_opcode_i == OP_REPORT) term_q <= TERM_FST;
        end
        ST_SYM: begin
          if (site_end) begin
            col_q <= '0;
            if (n1_new != '0 && n2_new != '0) begin
              term_q <= TERM_W1;
              n1_q   <= n1_new;
              n2_q   <= n2_new;
              s1_q   <= s1_new;
              s2_q   <= s2_new;
            end else begin
              n1_q <= '0;
              n2_q <= '0;
              s1_q <= '0;
              s2_q <= '0;
            end
          end else begin
            col_q <= AW'(col_next);
            n1_q  <= n1_new;
            n2_q  <= n2_new;
            s1_q  <= s1_new;
            s2_q  <= s2_new;
          end
        end
        ST_WAIT: begin
          if (div_rsp.done) begin
            priority case (term_q)
              TERM_W1: begin
                acc_w1_q <= acc_sat;
                term_q   <= TERM_W2;
              end
              TERM_W2: begin
                acc_w2_q <= acc_sat;
                term_q   <= TERM_B;
              end
              TERM_B: begin
                acc_b_q <= acc_sat;
                n1_q    <= '0;
                n2_q    <= '0;
                s1_q    <= '0;
                s2_q    <= '0;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) gch_q <= in_genotype_char_i;
    if (state_q == ST_IDLE && accept && in_opcode_i == OP_REPORT) begin
      fst_q    <= '0;
      fvalid_q <= 1'b0;
    end
    if (state_q == ST_TERM) neg_q <= fst_neg;
    if (state_q == ST_WAIT && div_rsp.done && term_q == TERM_FST) begin
      fst_q    <= fst_res;
      fvalid_q <= 1'b1;
    end
    if (state_q == ST_REPORT && out_free) begin
      out_pi_within_one_o <= acc_w1_q;
      out_pi_within_two_o <= acc_w2_q;
      out_pi_between_o    <= acc_b_q;
      out_fst_value_o     <= fst_q;
      out_fst_valid_o     <= fvalid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // divider finishes only while the controller waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_WAIT)
    else $error("divider done outside wait state");

  // site terms are computed only with both populations sampled
  a_term_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TERM && term_q != TERM_FST) |-> (n1_q != '0 && n2_q != '0))
    else $error("site division started with an empty population");

  // accumulators only grow
  a_acc_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (acc_w1_q >= $past(acc_w1_q) && acc_w2_q >= $past(acc_w2_q) &&
         acc_b_q >= $past(acc_b_q)))
    else $error("accumulator decreased");

endmodule
`default_nettype wire
